>>> hdl/ckh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckh_pkg
// Shared types and constants for the canonical k-mer hash stream.
// ----------------------------------------------------------------------------
package ckh_pkg;

	localparam int MAX_KMER_DEF = 127;
	localparam int KMER_BITS    = 256;
	localparam int FIFO_DEPTH   = 2;

	localparam logic [63:0] MUR_M    = 64'hc6a4a7935bd1e995;
	localparam int          MUR_R    = 47;
	localparam logic [63:0] MUR_INIT = MUR_M << 5;

	localparam logic [6:0]  KMER_LENGTH_RST = 7'd31;
	localparam logic [31:0] HASH_SEED_RST   = 32'd2038074761;
	localparam logic [6:0]  HASH_BITS_RST   = 7'd24;

	localparam logic [1:0] CFG_KMER_LENGTH = 2'd0;
	localparam logic [1:0] CFG_HASH_SEED   = 2'd1;
	localparam logic [1:0] CFG_HASH_BITS   = 2'd2;

	typedef struct packed {
		logic                 hash_valid;
		logic                 bad_base;
		logic [KMER_BITS-1:0] kmer;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_OUT
	} hash_state_t;

	typedef enum logic [1:0] {
		OP_V1,
		OP_V2,
		OP_H,
		OP_F
	} mul_op_t;

endpackage

>>> hdl/ckh_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckh_in_if / ckh_out_if
// Valid/ready channels for characters in and hash results out.
// ----------------------------------------------------------------------------
interface ckh_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] base_char;
	logic       last_of_read;
	modport source (output valid, output base_char, output last_of_read, input ready);
	modport sink (input valid, input base_char, input last_of_read, output ready);
endinterface

interface ckh_out_if;
	logic        valid;
	logic        ready;
	logic        hash_valid;
	logic [63:0] kmer_hash;
	logic        bad_base;
	modport source (output valid, output hash_valid, output kmer_hash, output bad_base,
		input ready);
	modport sink (input valid, input hash_valid, input kmer_hash, input bad_base,
		output ready);
endinterface

>>> hdl/ckh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckh_front
// Decodes characters, updates forward and reverse-complement windows, picks
// the canonical k-mer and queues one entry per transaction.
// ----------------------------------------------------------------------------
module ckh_front #(
	parameter int MAX_KMER = ckh_pkg::MAX_KMER_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	ckh_in_if.sink         base_in,
	input  logic [6:0]     kmer_length,
	output logic           push,
	output ckh_pkg::entry_t push_data,
	input  logic           full
);
	import ckh_pkg::*;

	localparam int W  = 2 * MAX_KMER;
	localparam int KW = $clog2(MAX_KMER + 1);

	logic [W-1:0]  fwd_q, rev_q, fwd_n, rev_n, mask, pick;
	logic [KW-1:0] run_q, run_n, k_eff;
	logic [1:0]    code;
	logic          good, hv, acc;

	assign base_in.ready = !full;
	assign acc = base_in.valid && base_in.ready;

	always_comb begin
		good = 1'b1;
		code = 2'd0;
		case (base_in.base_char)
			8'h41, 8'h61: code = 2'd0;
			8'h43, 8'h63: code = 2'd1;
			8'h47, 8'h67: code = 2'd2;
			8'h54, 8'h74: code = 2'd3;
			default:      good = 1'b0;
		endcase
	end

	always_comb begin
		if (kmer_length == 7'd0) begin
			k_eff = KW'(1);
		end else if (int'(kmer_length) > MAX_KMER) begin
			k_eff = KW'(MAX_KMER);
		end else begin
			k_eff = KW'(kmer_length);
		end
	end

	assign mask  = ~({W{1'b1}} << {k_eff, 1'b0});
	assign fwd_n = ((fwd_q << 2) | W'(code)) & mask;
	assign rev_n = ((rev_q >> 2) | (W'(~code) << {k_eff - KW'(1), 1'b0})) & mask;
	assign run_n = (run_q == KW'(MAX_KMER)) ? run_q : run_q + KW'(1);
	assign hv    = run_n >= k_eff;
	assign pick  = (rev_n < fwd_n) ? rev_n : fwd_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= '0;
			rev_q <= '0;
			run_q <= '0;
		end else if (acc) begin
			if (!good || base_in.last_of_read) begin
				fwd_q <= '0;
				rev_q <= '0;
				run_q <= '0;
			end else begin
				fwd_q <= fwd_n;
				rev_q <= rev_n;
				run_q <= run_n;
			end
		end
	end

	assign push                 = acc;
	assign push_data.hash_valid = good && hv;
	assign push_data.bad_base   = !good;
	assign push_data.kmer       = KMER_BITS'(pick);

endmodule

>>> hdl/ckh_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckh_fifo
// Short queue between the window front end and the hash engine.
// ----------------------------------------------------------------------------
module ckh_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ckh_pkg::entry_t push_data,
	output logic            full,
	input  logic            pop,
	output ckh_pkg::entry_t pop_data,
	output logic            empty
);
	import ckh_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);

	entry_t          mem_q [FIFO_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     cnt_q;

	assign full     = cnt_q == (PW+1)'(FIFO_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

>>> hdl/ckh_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckh_hash
// Iterative murmur hash engine on one 32x32 multiplier, with output register.
// ----------------------------------------------------------------------------
module ckh_hash (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  ckh_pkg::entry_t pop_data,
	output logic            pop,
	input  logic [31:0]     hash_seed,
	input  logic [6:0]      hash_bits,
	ckh_out_if.source       hash_out
);
	import ckh_pkg::*;

	hash_state_t st_q, st_n;
	mul_op_t     op_q;
	logic [1:0]  sub_q, wi_q;
	logic [63:0] a_q, h_q, acc_q, prod, r, r_mix, word_nx, hmask;
	logic [31:0] a_part, b_part;
	logic [KMER_BITS-1:0] kmer_q;
	logic        hv_q, bad_q;
	logic [63:0] hash_q;

	assign a_part  = (sub_q == 2'd2) ? a_q[63:32] : a_q[31:0];
	assign b_part  = (sub_q == 2'd1) ? MUR_M[63:32] : MUR_M[31:0];
	assign prod    = a_part * b_part;
	assign r       = (sub_q == 2'd0) ? prod : acc_q + {prod[31:0], 32'd0};
	assign r_mix   = r ^ (r >> MUR_R);
	assign word_nx = kmer_q[{wi_q + 2'd1, 6'd0} +: 64];
	assign hmask   = (hash_bits >= 7'd64) ? '1 : ~({64{1'b1}} << hash_bits[5:0]);

	always_comb begin
		st_n = st_q;
		pop  = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (!empty) begin
					pop  = 1'b1;
					st_n = pop_data.hash_valid ? ST_MUL : ST_OUT;
				end
			end
			ST_MUL: begin
				if (sub_q == 2'd2 && op_q == OP_F) begin
					st_n = ST_OUT;
				end
			end
			ST_OUT: begin
				if (hash_out.ready) begin
					st_n = ST_IDLE;
				end
			end
			default: st_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			sub_q <= '0;
		end else begin
			st_q <= st_n;
			if (st_q == ST_MUL) begin
				sub_q <= (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;
			end else begin
				sub_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && !empty) begin
			kmer_q <= pop_data.kmer;
			hv_q   <= pop_data.hash_valid;
			bad_q  <= pop_data.bad_base;
			hash_q <= '0;
			h_q    <= {32'd0, hash_seed} ^ MUR_INIT;
			a_q    <= pop_data.kmer[63:0];
			wi_q   <= '0;
			op_q   <= OP_V1;
		end else if (st_q == ST_MUL) begin
			acc_q <= r;
			if (sub_q == 2'd2) begin
				unique case (op_q)
					OP_V1: begin
						a_q  <= r_mix;
						op_q <= OP_V2;
					end
					OP_V2: begin
						a_q  <= h_q ^ r;
						op_q <= OP_H;
					end
					OP_H: begin
						h_q <= r;
						if (wi_q == 2'd3) begin
							a_q  <= r_mix;
							op_q <= OP_F;
						end else begin
							a_q  <= word_nx;
							wi_q <= wi_q + 2'd1;
							op_q <= OP_V1;
						end
					end
					OP_F: hash_q <= r_mix & hmask;
					default: op_q <= OP_V1;
				endcase
			end
		end
	end

	assign hash_out.valid      = st_q == ST_OUT;
	assign hash_out.hash_valid = hv_q;
	assign hash_out.kmer_hash  = hash_q;
	assign hash_out.bad_base   = bad_q;

	a_zero_hash: assert property (@(posedge clk) disable iff (!arst_n)
		hash_out.valid && !hash_out.hash_valid |-> hash_out.kmer_hash == 64'd0)
		else $error("hash not zero on invalid result");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		hash_out.valid |-> !(hash_out.hash_valid && hash_out.bad_base))
		else $error("hash and bad base together");
	a_sub: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_MUL |-> sub_q != 2'd3)
		else $error("multiplier phase out of range");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> st_q != ST_IDLE)
		else $error("entry popped but engine idle");

endmodule

>>> hdl/canonical_kmer_hash_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_kmer_hash_stream
// Streams DNA characters and emits the murmur hash of each canonical k-mer.
// ----------------------------------------------------------------------------
// base_in carries one ASCII character per transaction, with last_of_read on
// the final character of a read. hash_out returns exactly one result per
// character: hash_valid with the reduced hash once k valid bases are in the
// window, bad_base for anything but A/C/G/T, otherwise an empty result.
// The cfg port (cfg_we, cfg_idx, cfg_wdata) sets k, seed and hash width;
// the user must write it only while the block is idle, which is not enforced.
// The front end takes a character every cycle while its two-entry queue has
// room. The hash engine runs 13 64-bit multiplies on one 32x32 multiplier,
// each from three partial products, and holds one entry until its result
// is taken, so hashed characters set the sustained rate; a character with
// no hash skips the multiplies. A result waits in the output register while
// hash_out stalls; the queue fills behind it, then base_in.ready drops.
// Reset clears the windows, run count, queue and engine and loads the
// default configuration.
// ----------------------------------------------------------------------------
module canonical_kmer_hash_stream #(
	parameter int MAX_KMER = ckh_pkg::MAX_KMER_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ckh_in_if.sink      base_in,
	ckh_out_if.source   hash_out,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);
	import ckh_pkg::*;

	logic [6:0]  kmer_length_q, hash_bits_q;
	logic [31:0] hash_seed_q;
	logic        push, full, pop, empty;
	entry_t      push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q <= KMER_LENGTH_RST;
			hash_seed_q   <= HASH_SEED_RST;
			hash_bits_q   <= HASH_BITS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_KMER_LENGTH: kmer_length_q <= cfg_wdata[6:0];
				CFG_HASH_SEED:   hash_seed_q   <= cfg_wdata;
				CFG_HASH_BITS:   hash_bits_q   <= cfg_wdata[6:0];
				default:         ;
			endcase
		end
	end

	ckh_front #(.MAX_KMER(MAX_KMER)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.base_in     (base_in),
		.kmer_length (kmer_length_q),
		.push        (push),
		.push_data   (push_data),
		.full        (full)
	);

	ckh_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	ckh_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop_data  (pop_data),
		.pop       (pop),
		.hash_seed (hash_seed_q),
		.hash_bits (hash_bits_q),
		.hash_out  (hash_out)
	);

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the canonical k-mer hash stream.
// ----------------------------------------------------------------------------
// Feeds reads of DNA characters with random content and occasional bad bases
// through base_in, predicts each result with a bit-accurate window and murmur
// model, and compares every hash_out transaction in order. Phases step k,
// seed and hash width through their extremes between idle points, with
// bursty input, a stalling receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import ckh_pkg::*;

	localparam logic [63:0] MIX_M = 64'hc6a4a7935bd1e995;

	typedef struct {
		logic        hash_valid;
		logic [63:0] kmer_hash;
		logic        bad_base;
	} hash_result_t;

	class kmer_scoreboard;
		logic [6:0]   kmer_length;
		logic [31:0]  hash_seed;
		logic [6:0]   hash_bits;
		logic [255:0] fwd;
		logic [255:0] rev;
		int           run_len;
		hash_result_t pending[$];
		int           errors;

		function new();
			kmer_length = KMER_LENGTH_RST;
			hash_seed   = HASH_SEED_RST;
			hash_bits   = HASH_BITS_RST;
			fwd = '0;
			rev = '0;
			run_len = 0;
			errors = 0;
		endfunction

		function logic [63:0] murmur(logic [255:0] key);
			logic [63:0] h;
			logic [63:0] v;
			h = {32'd0, hash_seed} ^ (64'd32 * MIX_M);
			for (int i = 0; i < 4; i++) begin
				v = key[64*i +: 64];
				v = v * MIX_M;
				v = v ^ (v >> 47);
				v = v * MIX_M;
				h = (h ^ v) * MIX_M;
			end
			h = h ^ (h >> 47);
			h = h * MIX_M;
			h = h ^ (h >> 47);
			return h;
		endfunction

		function void note_base(logic [7:0] ch, logic last);
			hash_result_t r;
			int code;
			int k;
			int hb;
			logic [255:0] mask;
			logic [255:0] pick;
			r.hash_valid = 0;
			r.kmer_hash = '0;
			r.bad_base = 0;
			case (ch)
				"A", "a": code = 0;
				"C", "c": code = 1;
				"G", "g": code = 2;
				"T", "t": code = 3;
				default: code = 4;
			endcase
			if (code == 4) begin
				r.bad_base = 1;
				fwd = '0;
				rev = '0;
				run_len = 0;
			end else begin
				k = (kmer_length == 0) ? 1 : int'(kmer_length);
				mask = (256'd1 << (2 * k)) - 256'd1;
				fwd = ((fwd << 2) | 256'(code)) & mask;
				rev = ((rev >> 2) | (256'(3 ^ code) << (2 * (k - 1)))) & mask;
				if (run_len < 127)
					run_len++;
				if (run_len >= k) begin
					pick = (rev < fwd) ? rev : fwd;
					r.kmer_hash = murmur(pick);
					hb = (hash_bits > 64) ? 64 : int'(hash_bits);
					if (hb < 64)
						r.kmer_hash &= (64'd1 << hb) - 64'd1;
					r.hash_valid = 1;
				end
			end
			if (last) begin
				fwd = '0;
				rev = '0;
				run_len = 0;
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic hv, logic [63:0] kh, logic bb);
			hash_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected transaction on hash_out");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (hv !== e.hash_valid) begin
				$error("hash_valid expected %0d actual %0d", e.hash_valid, hv);
				errors++;
			end
			if (kh !== e.kmer_hash) begin
				$error("kmer_hash expected %h actual %h", e.kmer_hash, kh);
				errors++;
			end
			if (bb !== e.bad_base) begin
				$error("bad_base expected %0d actual %0d", e.bad_base, bb);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_idx = '0;
	logic [31:0] cfg_wdata = '0;
	logic        hold_off = 0;
	int          idle_cycles = 0;

	ckh_in_if  base_in();
	ckh_out_if hash_out();

	kmer_scoreboard sb = new();

	canonical_kmer_hash_stream u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.base_in(base_in.sink),
		.hash_out(hash_out.source),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	initial begin
		base_in.valid = 0;
		base_in.base_char = '0;
		base_in.last_of_read = 0;
		hash_out.ready = 0;
	end

	// input side scoreboard note and output check at the rising edge
	always @(posedge clk) begin
		if (base_in.valid && base_in.ready)
			sb.note_base(base_in.base_char, base_in.last_of_read);
		if (hash_out.valid && hash_out.ready)
			sb.check_result(hash_out.hash_valid, hash_out.kmer_hash, hash_out.bad_base);
		if ((base_in.valid && base_in.ready) || (hash_out.valid && hash_out.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles > 20000) begin
			$display("canonical_kmer_hash_stream verification failed");
			$finish;
		end
	end

	// receiver stall pattern
	initial begin
		int mode;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			mode = ($time / 40000) % 3;
			if (hold_off)
				hash_out.ready <= 0;
			else if (mode == 0)
				hash_out.ready <= 1;
			else if (mode == 1)
				hash_out.ready <= ($urandom_range(0, 3) != 0);
			else
				hash_out.ready <= ($urandom_range(0, 3) == 0);
		end
	end

	task automatic send_base(logic [7:0] ch, logic last);
		base_in.valid <= 1;
		base_in.base_char <= ch;
		base_in.last_of_read <= last;
		@(posedge clk);
		while (!base_in.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic pause_sender();
		base_in.valid <= 0;
		repeat ($urandom_range(1, 6))
			@(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			CFG_KMER_LENGTH: sb.kmer_length = val[6:0];
			CFG_HASH_SEED:   sb.hash_seed = val;
			default:         sb.hash_bits = val[6:0];
		endcase
	endtask

	task automatic drain();
		base_in.valid <= 0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (60)
			@(negedge clk);
	endtask

	function automatic logic [7:0] rand_base();
		logic [7:0] b;
		case ($urandom_range(0, 3))
			0: b = "A";
			1: b = "C";
			2: b = "G";
			default: b = "T";
		endcase
		if ($urandom_range(0, 1))
			b = b | 8'h20;
		return b;
	endfunction

	task automatic send_reads(int count, int kmax);
		int burst;
		int len;
		int sent;
		sent = 0;
		burst = $urandom_range(1, 30);
		while (sent < count) begin
			len = $urandom_range(1, kmax + 10);
			for (int i = 0; i < len && sent < count; i++) begin
				if ($urandom_range(0, 39) == 0)
					send_base(8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0));
				else
					send_base(rand_base(), (i == len - 1));
				sent++;
				burst--;
				if (burst == 0) begin
					if ($urandom_range(0, 2) != 0)
						pause_sender();
					burst = $urandom_range(1, 30);
				end
			end
		end
	endtask

	initial begin
		logic [7:0] dir_chars[$];
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: all codes in both cases, bad bases, palindrome, read ends
		dir_chars = '{"A", "C", "G", "T", "a", "c", "g", "t", 8'h00, 8'hff, "N",
			"A", "T", "G", "C", "A", "T", "x", "G", "G"};
		write_reg(CFG_KMER_LENGTH, 32'd4);
		for (int i = 0; i < dir_chars.size(); i++)
			send_base(dir_chars[i], (i == dir_chars.size() - 1) || (i == 14));
		drain();

		// zero length and zero width
		write_reg(CFG_KMER_LENGTH, 32'd0);
		write_reg(CFG_HASH_BITS, 32'd0);
		send_reads(60, 3);
		drain();

		// long hold-off while the sender keeps going
		write_reg(CFG_KMER_LENGTH, 32'd5);
		write_reg(CFG_HASH_BITS, 32'd64);
		write_reg(CFG_HASH_SEED, 32'hffffffff);
		fork
			begin
				hold_off = 1;
				repeat (400)
					@(negedge clk);
				hold_off = 0;
			end
			send_reads(40, 8);
		join
		drain();

		write_reg(CFG_KMER_LENGTH, 32'd127);
		write_reg(CFG_HASH_BITS, 32'd127);
		write_reg(CFG_HASH_SEED, 32'd0);
		send_reads(300, 140);
		drain();

		write_reg(CFG_KMER_LENGTH, 32'd1);
		write_reg(CFG_HASH_BITS, 32'd1);
		write_reg(CFG_HASH_SEED, 32'h80000000);
		send_reads(200, 4);
		drain();

		write_reg(CFG_KMER_LENGTH, 32'd32);
		write_reg(CFG_HASH_BITS, 32'd63);
		write_reg(CFG_HASH_SEED, 32'h12345678);
		send_reads(250, 40);
		drain();

		write_reg(CFG_KMER_LENGTH, 32'd33);
		write_reg(CFG_HASH_BITS, 32'd65);
		send_reads(200, 40);
		drain();

		for (int p = 0; p < 5; p++) begin
			write_reg(CFG_KMER_LENGTH, 32'($urandom_range(1, 127)));
			write_reg(CFG_HASH_BITS, 32'($urandom_range(0, 127)));
			write_reg(CFG_HASH_SEED, $urandom());
			send_reads(140, 70);
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("canonical_kmer_hash_stream verification clean");
		else
			$display("canonical_kmer_hash_stream verification failed");
		$finish;
	end

endmodule

>>> sim.f
hdl/ckh_pkg.sv
hdl/ckh_if.sv
hdl/ckh_front.sv
hdl/ckh_fifo.sv
hdl/ckh_hash.sv
hdl/canonical_kmer_hash_stream.sv
sim/tb_top.sv
